@@ src/chte_pkg.sv @@
// Shared types, codes and default sizes for the chained hash table engine.
package chte_pkg;

  localparam int unsigned SLOTS_DEF     = 256;
  localparam int unsigned BUCKETS_DEF   = 256;
  localparam int unsigned KEY_BYTES_DEF = 8;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned KLEN_W   = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned BCNT_W   = 9;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_MISS   = 2'd2
  } status_e;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key;
    logic [KLEN_W-1:0] key_len;
    logic [DATA_W-1:0] data;
  } pay_t;

endpackage

@@ src/chte_if.sv @@
// Request and response channel interfaces of the hash table engine.
interface chte_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        operation;
  logic [chte_pkg::HASH_W-1:0]       hash;
  logic [chte_pkg::KEY_W-1:0]        key;
  logic [chte_pkg::KLEN_W-1:0]       key_len;
  logic [chte_pkg::DATA_W-1:0]       data;
  logic [chte_pkg::HANDLE_W-1:0]     bucket_index;
  logic [chte_pkg::HANDLE_W-1:0]     slot_index;

  modport source (output valid, operation, hash, key, key_len, data, bucket_index,
                  slot_index, input ready);
  modport sink   (input valid, operation, hash, key, key_len, data, bucket_index,
                  slot_index, output ready);
endinterface

interface chte_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [chte_pkg::HANDLE_W-1:0]     found_slot;
  logic [chte_pkg::HANDLE_W-1:0]     found_bucket;
  logic [chte_pkg::HASH_W-1:0]       slot_hash;
  logic [chte_pkg::KEY_W-1:0]        slot_key;
  logic [chte_pkg::KLEN_W-1:0]       slot_key_len;
  logic [chte_pkg::DATA_W-1:0]       slot_data;
  logic [chte_pkg::COUNT_W-1:0]      entry_count;

  modport source (output valid, status, found_slot, found_bucket, slot_hash, slot_key,
                  slot_key_len, slot_data, entry_count, input ready);
  modport sink   (input valid, status, found_slot, found_bucket, slot_hash, slot_key,
                  slot_key_len, slot_data, entry_count, output ready);
endinterface

@@ src/chained_hash_table_engine_unit.sv @@
// Top level of the chained hash table engine: control sequencer and table memories.
//
//   channel   dir  handshake        payload
//   req_i     in   valid/ready      operation hash key key_len data bucket_index slot_index
//   rsp_o     out  valid/ready      status found_slot found_bucket slot_* entry_count
//   cfg       in   cfg_we_i         cfg_wdata_i = bucket total
//
// One operation at a time. Insert and lookup first reduce the hash modulo the bucket count
// in the remainder unit; insert writes one more link entry when its bucket already holds a
// chain, and lookup steps through the chain one entry at a time. Read and remove check the
// slot's link entry, and remove then updates link memory by read-modify-write; a request
// that fails its checks at the accepting cycle goes straight to the result.
// After reset a clearing pass over max(SLOTS, BUCKETS) entries initializes the link and
// bucket head memories; no request beat is taken during it.
// A finished result waits in the response register; the next request is taken
// while it waits, and the engine holds its next result until the register frees.
module chained_hash_table_engine_unit #(
  parameter int unsigned SLOTS     = chte_pkg::SLOTS_DEF,
  parameter int unsigned BUCKETS   = chte_pkg::BUCKETS_DEF,
  parameter int unsigned KEY_BYTES = chte_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  chte_req_if.sink                      req_i,
  chte_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [chte_pkg::BCNT_W-1:0]   cfg_wdata_i
);
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned PW    = $clog2(SLOTS + 1);
  localparam int unsigned BIW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int unsigned CLR_N = SLOTS > BUCKETS ? SLOTS : BUCKETS;
  localparam int unsigned CLRW  = $clog2(CLR_N);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  typedef struct packed {
    logic          occ;
    logic [PW-1:0] prev;
    logic [PW-1:0] next;
    logic [PW-1:0] free;
  } link_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_I_WR, ST_I_WROLD, ST_L_PTR, ST_L_CMP,
    ST_R_CHK, ST_M_PWR, ST_M_HC, ST_M_NWR, ST_M_SLOT, ST_DONE
  } state_e;

  state_e state_q;

  // Control and bookkeeping
  logic [CLRW-1:0]               clr_q;
  logic [PW-1:0]                 free_head_q, count_q, slot_q, cur_q, probes_q;
  logic [PW-1:0]                 old_q, p_q, n_q;
  logic [chte_pkg::BCNT_W-1:0]   bcnt_q, b_q;
  logic [1:0]                    op_q;
  logic [chte_pkg::HASH_W-1:0]   hash_q;
  logic [chte_pkg::KEY_W-1:0]    key_q;
  logic [chte_pkg::KLEN_W-1:0]   klen_q;
  logic [chte_pkg::DATA_W-1:0]   data_q;
  logic [chte_pkg::HANDLE_W-1:0] hb_q;

  // Pending result and response register
  chte_pkg::status_e             res_status_q;
  logic [chte_pkg::HANDLE_W-1:0] res_fslot_q, res_fbucket_q;
  chte_pkg::pay_t                res_pay_q;
  logic                          ov_q;
  chte_pkg::status_e             o_status_q;
  logic [chte_pkg::HANDLE_W-1:0] o_fslot_q, o_fbucket_q;
  chte_pkg::pay_t                o_pay_q;
  logic [chte_pkg::COUNT_W-1:0]  o_count_q;

  // Memory ports
  logic            link_we, link_re, head_we, head_re, pay_we, pay_re;
  logic [SW-1:0]   link_waddr, link_raddr, pay_waddr, pay_raddr;
  link_t           link_wdata, link_rd;
  logic [BIW-1:0]  head_waddr, head_raddr;
  logic [PW-1:0]   head_wdata, head_rd;
  chte_pkg::pay_t  pay_wdata, pay_rd;

  logic                        div_start, div_done;
  logic [chte_pkg::BCNT_W-1:0] div_rem, nb;
  logic                        accept, klen_ok, ins_ok, lkp_ok, hdl_ok, match, out_free;
  logic [chte_pkg::KEY_W-1:0]  key_masked;

  // Buckets in use: zero acts as one, above BUCKETS acts as BUCKETS
  always_comb begin
    if (bcnt_q == '0) begin
      nb = chte_pkg::BCNT_W'(1);
    end else if (32'(bcnt_q) > BUCKETS) begin
      nb = chte_pkg::BCNT_W'(BUCKETS);
    end else begin
      nb = bcnt_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_masked[8*i +: 8] = (32'(req_i.key_len) > i) ? req_i.key[8*i +: 8] : 8'h00;
    end
  end

  assign accept   = req_i.valid && req_i.ready;
  assign klen_ok  = (req_i.key_len != '0) && (32'(req_i.key_len) <= KEY_BYTES);
  assign ins_ok   = (count_q < NIL) && (free_head_q < NIL) && klen_ok;
  assign lkp_ok   = (count_q != '0) && klen_ok;
  assign hdl_ok   = (count_q != '0) && (32'(req_i.bucket_index) < 32'(nb))
                    && (32'(req_i.slot_index) < SLOTS);
  assign match    = link_rd.occ && (pay_rd.hash == hash_q) && (pay_rd.key_len == klen_q)
                    && (pay_rd.key == key_q);
  assign out_free = !ov_q || rsp_o.ready;
  assign div_start = accept && ((req_i.operation == chte_pkg::OP_INSERT && ins_ok) ||
                                (req_i.operation == chte_pkg::OP_LOOKUP && lkp_ok));

  assign req_i.ready = (state_q == ST_IDLE);

  // Memory port steering
  always_comb begin
    link_we    = 1'b0;
    link_waddr = SW'(slot_q);
    link_wdata = link_rd;
    link_re    = 1'b0;
    link_raddr = SW'(slot_q);
    head_we    = 1'b0;
    head_waddr = BIW'(b_q);
    head_wdata = n_q;
    head_re    = 1'b0;
    head_raddr = BIW'(div_rem);
    pay_we     = 1'b0;
    pay_waddr  = SW'(slot_q);
    pay_wdata  = '{hash: hash_q, key: key_q, key_len: klen_q, data: data_q};
    pay_re     = 1'b0;
    pay_raddr  = SW'(req_i.slot_index);
    case (state_q)
      ST_CLEAR: begin
        link_we    = (32'(clr_q) < SLOTS);
        link_waddr = SW'(clr_q);
        link_wdata = '{occ: 1'b0, prev: NIL, next: NIL, free: PW'(PW'(clr_q) + PW'(1))};
        head_we    = (32'(clr_q) < BUCKETS);
        head_waddr = BIW'(clr_q);
        head_wdata = NIL;
      end
      ST_IDLE: begin
        link_re    = accept;
        link_raddr = (req_i.operation == chte_pkg::OP_INSERT) ? SW'(free_head_q)
                                                              : SW'(req_i.slot_index);
        pay_re     = accept;
      end
      ST_DIV: begin
        head_re = div_done;
      end
      ST_I_WR: begin
        head_we    = 1'b1;
        head_wdata = slot_q;
        link_we    = 1'b1;
        link_wdata = '{occ: 1'b1, prev: NIL, next: head_rd, free: link_rd.free};
        pay_we     = 1'b1;
        link_re    = (head_rd < NIL);
        link_raddr = SW'(head_rd);
      end
      ST_I_WROLD: begin
        link_we    = 1'b1;
        link_waddr = SW'(old_q);
        link_wdata = '{occ: link_rd.occ, prev: slot_q, next: link_rd.next, free: link_rd.free};
      end
      ST_L_PTR: begin
        link_re    = (head_rd < NIL);
        link_raddr = SW'(head_rd);
        pay_re     = link_re;
        pay_raddr  = SW'(head_rd);
      end
      ST_L_CMP: begin
        link_re    = !match && (link_rd.next < NIL) && (32'(probes_q) != SLOTS - 1);
        link_raddr = SW'(link_rd.next);
        pay_re     = link_re;
        pay_raddr  = SW'(link_rd.next);
      end
      ST_R_CHK: begin
        link_re    = link_rd.occ && (link_rd.prev < NIL);
        link_raddr = SW'(link_rd.prev);
        head_re    = link_rd.occ && (link_rd.prev >= NIL);
        head_raddr = BIW'(hb_q);
      end
      ST_M_PWR: begin
        link_we    = 1'b1;
        link_waddr = SW'(p_q);
        link_wdata = '{occ: link_rd.occ, prev: link_rd.prev, next: n_q, free: link_rd.free};
        link_re    = (n_q < NIL);
        link_raddr = SW'(n_q);
      end
      ST_M_HC: begin
        head_we    = (head_rd == slot_q);
        head_waddr = BIW'(hb_q);
        link_re    = (head_rd == slot_q) && (n_q < NIL);
        link_raddr = SW'(n_q);
      end
      ST_M_NWR: begin
        link_we    = 1'b1;
        link_waddr = SW'(n_q);
        link_wdata = '{occ: link_rd.occ, prev: p_q, next: link_rd.next, free: link_rd.free};
      end
      ST_M_SLOT: begin
        link_we    = 1'b1;
        link_wdata = '{occ: 1'b0, prev: NIL, next: NIL, free: free_head_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      free_head_q   <= '0;
      count_q       <= '0;
      bcnt_q        <= chte_pkg::BCNT_W'(256);
      slot_q        <= '0;
      cur_q         <= '0;
      probes_q      <= '0;
      old_q         <= '0;
      p_q           <= '0;
      n_q           <= '0;
      b_q           <= '0;
      op_q          <= '0;
      hash_q        <= '0;
      key_q         <= '0;
      klen_q        <= '0;
      data_q        <= '0;
      hb_q          <= '0;
      res_status_q  <= chte_pkg::STATUS_REJECT;
      res_fslot_q   <= '0;
      res_fbucket_q <= '0;
      res_pay_q     <= '0;
      ov_q          <= 1'b0;
      o_status_q    <= chte_pkg::STATUS_REJECT;
      o_fslot_q     <= '0;
      o_fbucket_q   <= '0;
      o_pay_q       <= '0;
      o_count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        bcnt_q <= cfg_wdata_i;
      end
      // Drop the beat once taken, unless a new result replaces it this cycle
      if (ov_q && rsp_o.ready && state_q != ST_DONE) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == CLR_N - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_q          <= req_i.operation;
            hash_q        <= req_i.hash;
            key_q         <= key_masked;
            klen_q        <= req_i.key_len;
            data_q        <= req_i.data;
            hb_q          <= req_i.bucket_index;
            slot_q        <= (req_i.operation == chte_pkg::OP_INSERT) ? free_head_q
                                                                      : PW'(req_i.slot_index);
            res_status_q  <= chte_pkg::STATUS_REJECT;
            res_fslot_q   <= '0;
            res_fbucket_q <= '0;
            res_pay_q     <= '0;
            case (req_i.operation)
              chte_pkg::OP_INSERT: state_q <= ins_ok ? ST_DIV : ST_DONE;
              chte_pkg::OP_LOOKUP: state_q <= lkp_ok ? ST_DIV : ST_DONE;
              default:             state_q <= hdl_ok ? ST_R_CHK : ST_DONE;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            b_q     <= div_rem;
            state_q <= (op_q == chte_pkg::OP_INSERT) ? ST_I_WR : ST_L_PTR;
          end
        end
        ST_I_WR: begin
          free_head_q  <= link_rd.free;
          count_q      <= count_q + 1'b1;
          old_q        <= head_rd;
          res_status_q <= chte_pkg::STATUS_OK;
          res_fslot_q  <= chte_pkg::HANDLE_W'(slot_q);
          state_q      <= (head_rd < NIL) ? ST_I_WROLD : ST_DONE;
        end
        ST_I_WROLD: begin
          state_q <= ST_DONE;
        end
        ST_L_PTR: begin
          res_status_q <= chte_pkg::STATUS_MISS;
          cur_q        <= head_rd;
          probes_q     <= '0;
          state_q      <= (head_rd < NIL) ? ST_L_CMP : ST_DONE;
        end
        ST_L_CMP: begin
          if (match) begin
            res_status_q  <= chte_pkg::STATUS_OK;
            res_fslot_q   <= chte_pkg::HANDLE_W'(cur_q);
            res_fbucket_q <= chte_pkg::HANDLE_W'(b_q);
            state_q       <= ST_DONE;
          end else if (link_rd.next < NIL && 32'(probes_q) != SLOTS - 1) begin
            cur_q    <= link_rd.next;
            probes_q <= probes_q + 1'b1;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_R_CHK: begin
          p_q <= link_rd.prev;
          n_q <= link_rd.next;
          if (!link_rd.occ) begin
            state_q <= ST_DONE;
          end else if (op_q == chte_pkg::OP_READ) begin
            res_status_q <= chte_pkg::STATUS_OK;
            res_pay_q    <= pay_rd;
            state_q      <= ST_DONE;
          end else begin
            state_q <= (link_rd.prev < NIL) ? ST_M_PWR : ST_M_HC;
          end
        end
        ST_M_PWR: begin
          state_q <= (n_q < NIL) ? ST_M_NWR : ST_M_SLOT;
        end
        ST_M_HC: begin
          if (head_rd != slot_q) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= (n_q < NIL) ? ST_M_NWR : ST_M_SLOT;
          end
        end
        ST_M_NWR: begin
          state_q <= ST_M_SLOT;
        end
        ST_M_SLOT: begin
          free_head_q  <= slot_q;
          count_q      <= count_q - 1'b1;
          res_status_q <= chte_pkg::STATUS_OK;
          state_q      <= ST_DONE;
        end
        ST_DONE: begin
          // Hold the result until the response register frees
          if (out_free) begin
            ov_q        <= 1'b1;
            o_status_q  <= res_status_q;
            o_fslot_q   <= res_fslot_q;
            o_fbucket_q <= res_fbucket_q;
            o_pay_q     <= res_pay_q;
            o_count_q   <= chte_pkg::COUNT_W'(count_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  chte_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.hash),
    .divisor_i  (nb),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  chte_ram #(.WIDTH($bits(link_t)), .DEPTH(SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rd)
  );

  chte_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rd)
  );

  chte_ram #(.WIDTH($bits(chte_pkg::pay_t)), .DEPTH(SLOTS)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .re_i    (pay_re),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rd)
  );

  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = o_status_q;
  assign rsp_o.found_slot   = o_fslot_q;
  assign rsp_o.found_bucket = o_fbucket_q;
  assign rsp_o.slot_hash    = o_pay_q.hash;
  assign rsp_o.slot_key     = o_pay_q.key;
  assign rsp_o.slot_key_len = o_pay_q.key_len;
  assign rsp_o.slot_data    = o_pay_q.data;
  assign rsp_o.entry_count  = o_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NIL) else $error("occupied count above capacity");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV) else $error("remainder done outside divide state");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_I_WR |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not advance the count");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_M_SLOT |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not drop the count");
endmodule

@@ src/chte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module chte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

@@ src/chte_mod.sv @@
// Iterative remainder unit: 32-bit hash modulo a 9-bit bucket count, 4 bits a cycle.
module chte_mod (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [chte_pkg::HASH_W-1:0]        dividend_i,
  input  logic [chte_pkg::BCNT_W-1:0]        divisor_i,
  output logic                               done_o,
  output logic [chte_pkg::BCNT_W-1:0]        rem_o
);
  localparam int unsigned STEPS  = 4;
  localparam int unsigned ROUNDS = chte_pkg::HASH_W / STEPS;
  localparam int unsigned RCW    = $clog2(ROUNDS);

  logic [chte_pkg::HASH_W-1:0] dvd_q, dvd_d;
  logic [chte_pkg::BCNT_W:0]   rem_q, rem_d;
  logic [chte_pkg::BCNT_W-1:0] dsr_q;
  logic [RCW-1:0]              cnt_q;
  logic                        busy_q, done_q;

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int i = 0; i < STEPS; i++) begin
      rem_d = {rem_d[chte_pkg::BCNT_W-1:0], dvd_d[chte_pkg::HASH_W-1]};
      dvd_d = {dvd_d[chte_pkg::HASH_W-2:0], 1'b0};
      if (rem_d >= {1'b0, dsr_q}) begin
        rem_d = rem_d - {1'b0, dsr_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        dvd_q <= dvd_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RCW'(ROUNDS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[chte_pkg::BCNT_W-1:0];
endmodule

@@ test/tb_chained_hash_table_engine_unit.sv @@
// Testbench of the chained hash table engine: directed, full-table, bucket-count and random tests.
//
// Each test task sends request beats through one shared sender. At the accepting edge the
// table predictor in this module updates its own copy of the slot pool, free list and
// chains, and queues the expected response. A monitor takes every response beat and
// compares it field by field with the oldest queued response. The sender works in bursts
// with random gaps. The receiver drops ready on a pattern of its own, with stretches of
// steady ready between the stalls.
module tb_chained_hash_table_engine_unit;

  localparam int unsigned NSLOT = chte_pkg::SLOTS_DEF;
  localparam int unsigned NBKT  = chte_pkg::BUCKETS_DEF;
  localparam logic [8:0]  NIL   = 9'(NSLOT);
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct {
    chte_pkg::status_e status;
    logic [7:0]  found_slot;
    logic [7:0]  found_bucket;
    logic [31:0] slot_hash;
    logic [63:0] slot_key;
    logic [3:0]  slot_key_len;
    logic [63:0] slot_data;
    logic [8:0]  entry_count;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = 9'd256;

  chte_req_if req_if ();
  chte_rsp_if rsp_if ();

  chained_hash_table_engine_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Table shadow: slot contents, links, free list and the bucket-count register.
  logic [31:0] tbl_hash  [NSLOT];
  logic [63:0] tbl_key   [NSLOT];
  logic [3:0]  tbl_klen  [NSLOT];
  logic [63:0] tbl_data  [NSLOT];
  logic [8:0]  link_prev [NSLOT];
  logic [8:0]  link_next [NSLOT];
  logic [8:0]  free_link [NSLOT];
  logic        in_use    [NSLOT];
  logic [8:0]  head_of   [NBKT];
  logic [8:0]  free_top;
  logic [8:0]  live_count;
  logic [8:0]  bucket_reg;

  resp_t       pending_resp[$];
  int unsigned fail_count = 0;
  int unsigned resp_seen  = 0;
  int unsigned ops_sent [4] = '{0, 0, 0, 0};
  int unsigned ok_seen = 0, miss_seen = 0, reject_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  // Small pool of keys so that lookups hit and chains collide.
  logic [31:0] pool_hash [48];
  logic [63:0] pool_key  [48];
  logic [3:0]  pool_klen [48];

  function automatic logic [8:0] active_buckets();
    if (bucket_reg == 9'd0) return 9'd1;
    if (bucket_reg > 9'(NBKT)) return 9'(NBKT);
    return bucket_reg;
  endfunction

  function automatic logic [63:0] len_mask(logic [3:0] len);
    if (len >= 4'd8) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      in_use[i]    = 1'b0;
      link_prev[i] = NIL;
      link_next[i] = NIL;
      free_link[i] = (i + 1 < NSLOT) ? 9'(i + 1) : NIL;
    end
    for (int b = 0; b < NBKT; b++) head_of[b] = NIL;
    free_top   = 9'd0;
    live_count = 9'd0;
    bucket_reg = 9'd256;
  endfunction

  // Apply one request to the shadow table and return the response it should produce.
  function automatic resp_t table_apply(chte_pkg::op_e op, logic [31:0] h, logic [63:0] k,
                                        logic [3:0] kl, logic [63:0] d,
                                        logic [7:0] hb, logic [7:0] hs);
    resp_t r;
    logic [8:0] nb, bkt, s, cur, p, n;
    logic [63:0] km;
    bit   key_ok, ok;
    r = '{chte_pkg::STATUS_REJECT, 8'd0, 8'd0, 32'd0, 64'd0, 4'd0, 64'd0, 9'd0};
    nb = active_buckets();
    key_ok = (kl >= 4'd1) && (kl <= 4'd8);
    bkt = 9'(h % 32'(nb));
    case (op)
      chte_pkg::OP_INSERT: begin
        if (live_count < 9'(NSLOT) && free_top < 9'(NSLOT) && key_ok) begin
          s = free_top;
          free_top = free_link[s];
          in_use[s] = 1'b1;
          tbl_hash[s] = h;
          tbl_key[s] = k & len_mask(kl);
          tbl_klen[s] = kl;
          tbl_data[s] = d;
          link_prev[s] = NIL;
          link_next[s] = head_of[bkt];
          if (head_of[bkt] < NIL) link_prev[head_of[bkt]] = s;
          head_of[bkt] = s;
          live_count++;
          r.status = chte_pkg::STATUS_OK;
          r.found_slot = s[7:0];
        end
      end
      chte_pkg::OP_LOOKUP: begin
        if (live_count != 0 && key_ok) begin
          km = k & len_mask(kl);
          cur = head_of[bkt];
          r.status = chte_pkg::STATUS_MISS;
          for (int probe = 0; probe < NSLOT && cur < NIL; probe++) begin
            if (in_use[cur] && tbl_hash[cur] == h && tbl_klen[cur] == kl &&
                tbl_key[cur] == km) begin
              r.status = chte_pkg::STATUS_OK;
              r.found_slot = cur[7:0];
              r.found_bucket = bkt[7:0];
              break;
            end
            cur = link_next[cur];
          end
        end
      end
      default: begin
        ok = live_count != 0 && 9'(hb) < nb && in_use[hs];
        if (ok && op == chte_pkg::OP_REMOVE) begin
          p = link_prev[hs];
          n = link_next[hs];
          // A chain head can only be unlinked through its own bucket.
          if (p >= NIL && head_of[hb] != 9'(hs)) ok = 0;
          if (ok) begin
            if (p < NIL) link_next[p] = n;
            else head_of[hb] = n;
            if (n < NIL) link_prev[n] = p;
            link_prev[hs] = NIL;
            link_next[hs] = NIL;
            free_link[hs] = free_top;
            free_top = 9'(hs);
            in_use[hs] = 1'b0;
            live_count--;
            r.status = chte_pkg::STATUS_OK;
          end
        end else if (ok) begin
          r.status = chte_pkg::STATUS_OK;
          r.slot_hash = tbl_hash[hs];
          r.slot_key = tbl_key[hs];
          r.slot_key_len = tbl_klen[hs];
          r.slot_data = tbl_data[hs];
        end
      end
    endcase
    r.entry_count = live_count;
    return r;
  endfunction

  // Drive one request beat, hold it until accepted, then advance the burst pattern.
  task automatic send_req(chte_pkg::op_e op, logic [31:0] h, logic [63:0] k, logic [3:0] kl,
                          logic [63:0] d, logic [7:0] hb, logic [7:0] hs);
    int unsigned gap;
    req_if.valid        = 1'b1;
    req_if.operation    = op;
    req_if.hash         = h;
    req_if.key          = k;
    req_if.key_len      = kl;
    req_if.data         = d;
    req_if.bucket_index = hb;
    req_if.slot_index   = hs;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_resp.push_back(table_apply(op, h, k, kl, d, hb, hs));
    ops_sent[op]++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Hold off until every queued response has arrived and the engine has settled.
  task automatic drain_all();
    req_if.valid = 1'b0;
    while (pending_resp.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_buckets(logic [8:0] value);
    drain_all();
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    bucket_reg = value;
  endtask

  function automatic logic [7:0] head_bucket_of(logic [7:0] s);
    return 8'(tbl_hash[s] % 32'(active_buckets()));
  endfunction

  // Receiver: stall on a slowly varying pattern, sometimes steady for a long stretch.
  int unsigned stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9:7] == 3'd5) rsp_if.ready <= 1'b1;
    else rsp_if.ready <= ($urandom_range(0, 99) < 70);
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Take every response beat and compare it with the oldest expectation.
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_resp.size() == 0) begin
        fail_count++;
        $display("%0t: response beat with none expected, status %0d", $realtime,
                 rsp_if.status);
      end else begin
        e = pending_resp.pop_front();
        resp_seen++;
        case (e.status)
          chte_pkg::STATUS_OK:   ok_seen++;
          chte_pkg::STATUS_MISS: miss_seen++;
          default:               reject_seen++;
        endcase
        check_field("status", 64'(e.status), 64'(rsp_if.status));
        check_field("found_slot", 64'(e.found_slot), 64'(rsp_if.found_slot));
        check_field("found_bucket", 64'(e.found_bucket), 64'(rsp_if.found_bucket));
        check_field("slot_hash", 64'(e.slot_hash), 64'(rsp_if.slot_hash));
        check_field("slot_key", e.slot_key, rsp_if.slot_key);
        check_field("slot_key_len", 64'(e.slot_key_len), 64'(rsp_if.slot_key_len));
        check_field("slot_data", e.slot_data, rsp_if.slot_data);
        check_field("entry_count", 64'(e.entry_count), 64'(rsp_if.entry_count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("chained_hash_table_engine_unit test failed");
      $finish;
    end
  end

  // Empty-table rejects, invalid key lengths, hits, misses, masked key bytes, handles.
  task automatic test_directed();
    logic [63:0] d;
    send_req(chte_pkg::OP_LOOKUP, 32'h1, 64'h1, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_REMOVE, 32'h0, 64'h0, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_READ,   32'h0, 64'h0, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_INSERT, 32'h5, 64'h5, 4'd0, 64'd1, 8'd0, 8'd0);
    send_req(chte_pkg::OP_INSERT, 32'h5, 64'h5, 4'd9, 64'd1, 8'd0, 8'd0);
    send_req(chte_pkg::OP_INSERT, 32'h5, 64'h5, 4'd15, 64'd1, 8'd0, 8'd0);
    send_req(chte_pkg::OP_INSERT, '1, '1, 4'd8, '1, 8'hff, 8'hff);
    send_req(chte_pkg::OP_INSERT, 32'h0, 64'hdead_beef_0000_00a5, 4'd1, 64'h0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_INSERT, 32'h100, 64'h1234, 4'd2, 64'h77, 8'd0, 8'd0);
    send_req(chte_pkg::OP_INSERT, 32'h200, 64'h1234, 4'd2, 64'h88, 8'd0, 8'd0);
    // Bytes above the key length must not matter.
    send_req(chte_pkg::OP_LOOKUP, 32'h0, 64'hffff_ffff_ffff_ffa5, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, '1, '1, 4'd8, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'h100, 64'h1234, 4'd2, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'h100, 64'h1234, 4'd3, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'h300, 64'h1234, 4'd2, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'h100, 64'h1234, 4'd0, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_READ,   32'h0, 64'h0, 4'd0, 64'd0, 8'd255, 8'd0);
    send_req(chte_pkg::OP_READ,   32'h0, 64'h0, 4'd0, 64'd0, 8'd0, 8'd200);
    // Slot 2 is mid-chain in bucket 0, slot 3 heads it: wrong bucket on the head rejects.
    send_req(chte_pkg::OP_REMOVE, 32'h0, 64'h0, 4'd0, 64'd0, 8'd9, 8'd3);
    send_req(chte_pkg::OP_REMOVE, 32'h0, 64'h0, 4'd0, 64'd0, 8'd9, 8'd2);
    send_req(chte_pkg::OP_REMOVE, 32'h0, 64'h0, 4'd0, 64'd0, 8'd0, 8'd3);
    send_req(chte_pkg::OP_REMOVE, 32'h0, 64'h0, 4'd0, 64'd0, 8'd0, 8'd3);
    d = {$urandom, $urandom};
    send_req(chte_pkg::OP_INSERT, 32'h400, 64'h99, 4'd1, d, 8'd0, 8'd0);
    send_req(chte_pkg::OP_READ,   32'h0, 64'h0, 4'd0, 64'd0, 8'd0, 8'd3);
    send_req(chte_pkg::OP_READ,   32'h0, 64'h0, 4'd0, 64'd0, 8'd255, 8'd0);
  endtask

  // Fill every slot, overflow once, free a few and reuse one, then empty the table.
  task automatic test_full_table();
    logic [7:0] s;
    for (int i = 0; i < NSLOT; i++)
      send_req(chte_pkg::OP_INSERT, $urandom, {$urandom, $urandom}, 4'(1 + i % 8),
               {$urandom, $urandom}, 8'd0, 8'd0);
    send_req(chte_pkg::OP_INSERT, 32'h1, 64'h1, 4'd1, 64'd1, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, $urandom, {$urandom, $urandom}, 4'd8, 64'd0, 8'd0, 8'd0);
    for (int i = 0; i < 6; i++) begin
      s = 8'($urandom_range(0, NSLOT - 1));
      send_req(chte_pkg::OP_LOOKUP, tbl_hash[s], tbl_key[s], tbl_klen[s], 64'd0, 8'd0, 8'd0);
      send_req(chte_pkg::OP_READ, 32'd0, 64'd0, 4'd0, 64'd0, head_bucket_of(s), s);
      send_req(chte_pkg::OP_REMOVE, 32'd0, 64'd0, 4'd0, 64'd0, head_bucket_of(s), s);
    end
    send_req(chte_pkg::OP_INSERT, 32'h2, 64'h2, 4'd2, 64'd2, 8'd0, 8'd0);
    // Empty the table through valid handles.
    for (int i = 0; i < NSLOT; i++)
      if (in_use[i])
        send_req(chte_pkg::OP_REMOVE, 32'd0, 64'd0, 4'd0, 64'd0, head_bucket_of(8'(i)),
                 8'(i));
    send_req(chte_pkg::OP_READ, 32'd0, 64'd0, 4'd0, 64'd0, 8'd0, 8'd0);
  endtask

  // Small, zero and oversize bucket counts, and a change with entries present.
  task automatic test_bucket_count();
    write_buckets(9'd1);
    for (int i = 0; i < 6; i++)
      send_req(chte_pkg::OP_INSERT, 32'(i * 77), 64'(i), 4'd1, 64'(i), 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'd0, 64'd0, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_READ, 32'd0, 64'd0, 4'd0, 64'd0, 8'd1, 8'd2);
    send_req(chte_pkg::OP_REMOVE, 32'd0, 64'd0, 4'd0, 64'd0, 8'd0, 8'd2);
    write_buckets(9'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'd77, 64'd1, 4'd1, 64'd0, 8'd0, 8'd0);
    write_buckets(9'd7);
    // Older entries sit in the bucket 0 chain; their hashes are multiples of 77, so still bucket 0.
    send_req(chte_pkg::OP_LOOKUP, 32'd154, 64'd2, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'd385, 64'd5, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_READ, 32'd0, 64'd0, 4'd0, 64'd0, 8'd7, 8'd1);
    send_req(chte_pkg::OP_REMOVE, 32'd0, 64'd0, 4'd0, 64'd0, 8'd0, 8'd5);
    write_buckets(9'd511);
    send_req(chte_pkg::OP_INSERT, 32'hffff_ff00, 64'h3, 4'd1, 64'h3, 8'd0, 8'd0);
    send_req(chte_pkg::OP_LOOKUP, 32'hffff_ff00, 64'h3, 4'd1, 64'd0, 8'd0, 8'd0);
    send_req(chte_pkg::OP_READ, 32'd0, 64'd0, 4'd0, 64'd0, 8'd255, 8'd0);
    write_buckets(9'd256);
  endtask

  // Mostly well-formed traffic over a shared key pool, with some noise mixed in.
  task automatic test_random(int unsigned n_items);
    int unsigned pick, idx;
    logic [7:0] s;
    bit hit;
    for (int i = 0; i < 48; i++) begin
      pool_klen[i] = 4'($urandom_range(1, 8));
      pool_key[i]  = {$urandom, $urandom};
      pool_hash[i] = (i < 16) ? 32'($urandom_range(0, 3)) : $urandom;
    end
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      idx = $urandom_range(0, 47);
      if (live_count > 200 && pick < 40) pick = 60;
      s = 8'($urandom_range(0, NSLOT - 1));
      hit = 0;
      for (int t = 0; t < NSLOT && !hit; t++)
        if (in_use[8'(s + t)]) begin
          s = 8'(s + t);
          hit = 1;
        end
      if (pick < 35)
        send_req(chte_pkg::OP_INSERT, pool_hash[idx],
                 {$urandom, $urandom} & len_mask(pool_klen[idx]) |
                 pool_key[idx] & len_mask(pool_klen[idx]), pool_klen[idx],
                 {$urandom, $urandom}, 8'($urandom), 8'($urandom));
      else if (pick < 62)
        send_req(chte_pkg::OP_LOOKUP, pool_hash[idx], pool_key[idx] | ({$urandom, $urandom} &
                 ~len_mask(pool_klen[idx])), pool_klen[idx], {$urandom, $urandom},
                 8'($urandom), 8'($urandom));
      else if (pick < 82)
        send_req(chte_pkg::OP_REMOVE, $urandom, {$urandom, $urandom}, 4'($urandom),
                 {$urandom, $urandom}, hit ? head_bucket_of(s) : 8'($urandom), s);
      else if (pick < 92)
        send_req(chte_pkg::OP_READ, $urandom, {$urandom, $urandom}, 4'($urandom),
                 {$urandom, $urandom}, hit ? head_bucket_of(s) : 8'($urandom), s);
      else
        send_req(chte_pkg::op_e'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                 4'($urandom), {$urandom, $urandom}, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.operation = chte_pkg::OP_INSERT;
    req_if.hash = '0;
    req_if.key = '0;
    req_if.key_len = '0;
    req_if.data = '0;
    req_if.bucket_index = '0;
    req_if.slot_index = '0;
    clear_table();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_table();
    test_bucket_count();
    test_random(100);
    drain_all();
    write_buckets(9'd3);
    test_random(60);
    write_buckets(9'd1);
    test_random(60);
    write_buckets(9'd256);
    test_random(60);
    // Let the engine run dry again between random runs.
    drain_all();
    test_random(50);

    drain_all();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run covered %0d inserts, %0d lookups, %0d removes, %0d reads; %0d responses",
             ops_sent[chte_pkg::OP_INSERT], ops_sent[chte_pkg::OP_LOOKUP],
             ops_sent[chte_pkg::OP_REMOVE], ops_sent[chte_pkg::OP_READ], resp_seen);
    $display("Outcomes: %0d ok, %0d not found, %0d rejected, over bucket counts 0..511",
             ok_seen, miss_seen, reject_seen);
    if (fail_count == 0 && pending_resp.size() == 0) begin
      $display("chained_hash_table_engine_unit test passed");
    end else begin
      $display("chained_hash_table_engine_unit test failed");
    end
    $finish;
  end

endmodule
